### rtl/core/dffr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dffr_pkg;

  // field storage geometry
  localparam int unsigned MaxFields = 16;
  localparam int unsigned FieldIdxW = $clog2(MaxFields);
  localparam int unsigned FieldCntW = $clog2(MaxFields + 1);

  // byte codes
  localparam logic [7:0] FieldSeparator = 8'h3B;
  localparam logic [7:0] DigitZero      = 8'h30;
  localparam logic [7:0] DigitNine      = 8'h39;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADER     = 3'd0,
    CFG_FOOTER     = 3'd1,
    CFG_TERMINATOR = 3'd2,
    CFG_CHK_LIMIT  = 3'd3,
    CFG_FIELD_LIM  = 3'd4
  } cfg_idx_e;

  // configuration reset values
  localparam logic [7:0] HeaderRst     = 8'd36;
  localparam logic [7:0] FooterRst     = 8'd42;
  localparam logic [7:0] TerminatorRst = 8'd10;
  localparam logic [3:0] ChkLimitRst   = 4'd3;
  localparam logic [4:0] FieldLimRst   = 5'd16;

  // parser phase
  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_COLLECT = 3'b010,
    PH_CHECK   = 3'b100
  } phase_e;

  // field store write request from the parser
  typedef struct packed {
    logic                 en;
    logic [FieldIdxW-1:0] addr;
    logic [15:0]          data;
  } store_wr_t;

  // end-of-frame command: error result or a burst of fields
  typedef struct packed {
    logic                 err;
    logic [FieldIdxW-1:0] last_idx;
  } frame_cmd_t;

endpackage

`default_nettype wire

### rtl/core/delimited_frame_field_receiver_top.sv
// Flow: one byte is taken per cycle while in_ready_o is high. A frame's first
// result goes from its terminator through the command FIFO, the sequencer and
// the output register; then one result per cycle while out_ready_i is high.
// No new byte is taken while a frame's results are emitted from the store.
// Reset: asynchronous active low; parser hunts for a header, config registers
// return to defaults, field store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_field_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      field_value_o,
  output logic [3:0]       field_index_o,
  output logic             status_o,
  output logic             last_o
);

  dffr_pkg::store_wr_t  store_wr;
  dffr_pkg::frame_cmd_t push_cmd, head_cmd;
  logic cmd_push, cmd_pop, fifo_empty, emit_busy, accept;

  // bytes are held off while a frame burst is pending
  assign in_ready_o  = fifo_empty && !emit_busy;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  dffr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .store_wr_o  (store_wr),
    .cmd_push_o  (cmd_push),
    .cmd_o       (push_cmd)
  );

  dffr_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .pop_i      (cmd_pop),
    .empty_o    (fifo_empty),
    .head_o     (head_cmd)
  );

  dffr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .store_wr_i    (store_wr),
    .cmd_avail_i   (!fifo_empty),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (cmd_pop),
    .busy_o        (emit_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_value_o (field_value_o),
    .field_index_o (field_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

### rtl/core/dffr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dffr_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [7:0]            cfg_data_i,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            rx_byte_i,
  output dffr_pkg::store_wr_t        store_wr_o,
  output logic                       cmd_push_o,
  output dffr_pkg::frame_cmd_t       cmd_o
);

  logic [7:0] header_q, footer_q, term_q;
  logic [3:0] chk_limit_q;
  logic [4:0] field_lim_q;

  dffr_pkg::phase_e phase_q, phase_d;
  logic [dffr_pkg::FieldCntW-1:0] fcount_q, fcount_d;
  logic [15:0] acc_q, acc_d;
  logic        closed_q, closed_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  rcv_q, rcv_d;
  logic [3:0]  cbc_q, cbc_d;

  logic        is_digit;
  logic [3:0]  digit;
  logic [4:0]  next_cbc;
  logic [dffr_pkg::FieldCntW-1:0] lim_clamped, emit_cnt;
  logic [15:0] acc_times_ten;
  logic [7:0]  rcv_times_ten;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= dffr_pkg::HeaderRst;
      footer_q    <= dffr_pkg::FooterRst;
      term_q      <= dffr_pkg::TerminatorRst;
      chk_limit_q <= dffr_pkg::ChkLimitRst;
      field_lim_q <= dffr_pkg::FieldLimRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dffr_pkg::CFG_HEADER:     header_q    <= cfg_data_i;
        dffr_pkg::CFG_FOOTER:     footer_q    <= cfg_data_i;
        dffr_pkg::CFG_TERMINATOR: term_q      <= cfg_data_i;
        dffr_pkg::CFG_CHK_LIMIT:  chk_limit_q <= cfg_data_i[3:0];
        dffr_pkg::CFG_FIELD_LIM:  field_lim_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // byte classification and decimal accumulate
  assign is_digit      = (rx_byte_i >= dffr_pkg::DigitZero) && (rx_byte_i <= dffr_pkg::DigitNine);
  assign digit         = is_digit ? rx_byte_i[3:0] : 4'd0;
  assign acc_times_ten = (acc_q << 3) + (acc_q << 1) + {12'd0, digit};
  assign rcv_times_ten = (rcv_q << 3) + (rcv_q << 1) + {4'd0, digit};
  assign next_cbc      = {1'b0, cbc_q} + 5'd1;

  // number of fields to emit, limit clamped to 1..MaxFields
  always_comb begin
    if (field_lim_q == 5'd0) begin
      lim_clamped = dffr_pkg::FieldCntW'(1);
    end else if (dffr_pkg::FieldCntW'(field_lim_q) > dffr_pkg::FieldCntW'(dffr_pkg::MaxFields)) begin
      lim_clamped = dffr_pkg::FieldCntW'(dffr_pkg::MaxFields);
    end else begin
      lim_clamped = dffr_pkg::FieldCntW'(field_lim_q);
    end
    emit_cnt = (fcount_q < lim_clamped) ? fcount_q : lim_clamped;
  end

  // parser next state
  always_comb begin
    phase_d    = phase_q;
    fcount_d   = fcount_q;
    acc_d      = acc_q;
    closed_d   = closed_q;
    xor_d      = xor_q;
    rcv_d      = rcv_q;
    cbc_d      = cbc_q;
    store_wr_o = '0;
    cmd_push_o = 1'b0;
    cmd_o      = '0;

    unique case (phase_q)
      dffr_pkg::PH_COLLECT: begin
        if (rx_byte_i == footer_q || rx_byte_i != header_q) begin
          xor_d = xor_q ^ rx_byte_i;
        end
        if (rx_byte_i == footer_q || (rx_byte_i != header_q
                                      && rx_byte_i == dffr_pkg::FieldSeparator)) begin
          // close the current field
          if (fcount_q < dffr_pkg::FieldCntW'(dffr_pkg::MaxFields)) begin
            store_wr_o.en   = 1'b1;
            store_wr_o.addr = fcount_q[dffr_pkg::FieldIdxW-1:0];
            store_wr_o.data = acc_q;
            fcount_d        = fcount_q + dffr_pkg::FieldCntW'(1);
          end
          acc_d    = '0;
          closed_d = 1'b0;
          if (rx_byte_i == footer_q) begin
            phase_d = dffr_pkg::PH_CHECK;
            rcv_d   = '0;
            cbc_d   = '0;
          end
        end else if (rx_byte_i == header_q) begin
          phase_d  = dffr_pkg::PH_COLLECT;
          xor_d    = rx_byte_i;
          fcount_d = '0;
          acc_d    = '0;
          closed_d = 1'b0;
          rcv_d    = '0;
          cbc_d    = '0;
        end else if (is_digit && !closed_q) begin
          acc_d = acc_times_ten;
        end else begin
          closed_d = 1'b1;
        end
      end
      dffr_pkg::PH_CHECK: begin
        if (rx_byte_i == term_q) begin
          // frame complete: error result or field burst
          cmd_o.err      = (rcv_q != xor_q);
          cmd_o.last_idx = dffr_pkg::FieldIdxW'(emit_cnt - dffr_pkg::FieldCntW'(1));
          cmd_push_o     = (rcv_q != xor_q) || (emit_cnt != '0);
          phase_d        = dffr_pkg::PH_SEARCH;
          cbc_d          = '0;
        end else if (next_cbc > {1'b0, chk_limit_q}) begin
          phase_d = dffr_pkg::PH_SEARCH;
          cbc_d   = '0;
        end else if (rx_byte_i == header_q) begin
          phase_d  = dffr_pkg::PH_COLLECT;
          xor_d    = rx_byte_i;
          fcount_d = '0;
          acc_d    = '0;
          closed_d = 1'b0;
          rcv_d    = '0;
          cbc_d    = '0;
        end else begin
          cbc_d = next_cbc[3:0];
          if (is_digit && !closed_q) begin
            rcv_d = rcv_times_ten;
          end else begin
            closed_d = 1'b1;
          end
        end
      end
      default: begin
        // searching, and any stray code acts as searching
        if (rx_byte_i == header_q) begin
          phase_d  = dffr_pkg::PH_COLLECT;
          xor_d    = rx_byte_i;
          fcount_d = '0;
          acc_d    = '0;
          closed_d = 1'b0;
          rcv_d    = '0;
          cbc_d    = '0;
        end else begin
          phase_d = dffr_pkg::PH_SEARCH;
        end
      end
    endcase

    if (!accept_i) begin
      store_wr_o.en = 1'b0;
      cmd_push_o    = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dffr_pkg::PH_SEARCH;
      fcount_q <= '0;
      acc_q    <= '0;
      closed_q <= 1'b0;
      xor_q    <= '0;
      rcv_q    <= '0;
      cbc_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      fcount_q <= fcount_d;
      acc_q    <= acc_d;
      closed_q <= closed_d;
      xor_q    <= xor_d;
      rcv_q    <= rcv_d;
      cbc_q    <= cbc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dffr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dffr_cmd_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire dffr_pkg::frame_cmd_t push_cmd_i,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output dffr_pkg::frame_cmd_t      head_o
);

  dffr_pkg::frame_cmd_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign empty_o = (count_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/core/dffr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module dffr_emit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dffr_pkg::store_wr_t  store_wr_i,
  input  wire logic                 cmd_avail_i,
  input  wire dffr_pkg::frame_cmd_t cmd_i,
  output logic                      cmd_pop_o,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [15:0]               field_value_o,
  output logic [3:0]                field_index_o,
  output logic                      status_o,
  output logic                      last_o
);

  logic [15:0] store_q [dffr_pkg::MaxFields];

  logic                          active_q;
  logic                          err_q;
  logic [dffr_pkg::FieldIdxW-1:0] idx_q, last_idx_q;
  logic                          out_valid_q;
  logic                          load;
  logic                          is_last;

  // field store, written by the parser
  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_q[store_wr_i.addr] <= store_wr_i.data;
    end
  end

  assign cmd_pop_o = cmd_avail_i && !active_q;
  assign load      = active_q && (!out_valid_q || out_ready_i);
  assign is_last   = err_q || (idx_q == last_idx_q);
  assign busy_o    = active_q;

  // burst sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      err_q       <= 1'b0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        active_q   <= 1'b1;
        err_q      <= cmd_i.err;
        idx_q      <= '0;
        last_idx_q <= cmd_i.last_idx;
      end else if (load) begin
        if (is_last) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q + dffr_pkg::FieldIdxW'(1);
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register, registered store read
  always_ff @(posedge clk_i) begin
    if (load) begin
      field_value_o <= err_q ? 16'd0 : store_q[idx_q];
      field_index_o <= err_q ? 4'd0 : 4'(idx_q);
      status_o      <= err_q;
      last_o        <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
